[design/crre_pkg.sv]
// Shared types, codes and constants for the channel request/retransmit engine.
// Used by crre_ram's users, crre_ctrl, crre_datapath and the top level.
package crre_pkg;

   localparam int HEADER_BYTES        = 4;
   localparam int RESULT_CAP          = 8;
   localparam int DEF_CHANNELS        = 8;
   localparam int DEF_MAX_FRAME_BYTES = 64;

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 48;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int EMIT_W     = $clog2(RESULT_CAP + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_PROTOCOL_VERSION = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEND_DELAY       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_INTERVAL   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REQUEST_TYPE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLY_TYPE       = 3'd4;

   localparam logic [3:0]  RST_PROTOCOL_VERSION = 4'd1;
   localparam logic [15:0] RST_SEND_DELAY       = 16'd100;
   localparam logic [15:0] RST_RETRY_INTERVAL   = 16'd1000;
   localparam logic [3:0]  RST_REQUEST_TYPE     = 4'd1;
   localparam logic [3:0]  RST_REPLY_TYPE       = 4'd2;

   typedef enum logic [1:0] {
      OP_SEND  = 2'd0,
      OP_REPLY = 2'd1,
      OP_RECV  = 2'd2,
      OP_TICK  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_STATUS  = 2'd0,
      KIND_TX      = 2'd1,
      KIND_DELIVER = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_TOO_LONG    = 3'd1,
      ST_BUSY        = 3'd2,
      ST_BAD_CHANNEL = 3'd3,
      ST_BAD_VERSION = 3'd4,
      ST_TOO_SHORT   = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_DECODE,
      FSM_SEND_CHK,
      FSM_RECV_ROW,
      FSM_STATUS,
      FSM_FINISH,
      FSM_SCAN_RD,
      FSM_SCAN_EV
   } fsm_type;

   typedef struct packed {
      kind_type    kind;
      status_type  status;
      logic [7:0]  channel;
      logic [3:0]  mtype;
      logic [15:0] seq;
      logic [15:0] length;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic       rd_item;
      logic       rd_scan;
      logic       scan_clear;
      logic       scan_next;
      logic       set_lrt;
      logic       send_disp;
      logic       tick_disp;
      logic       recv_row;
      logic       push_status;
      status_type st;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   too_long;
      logic   bad_channel;
      logic   too_short;
      logic   bad_version;
      logic   busy;
      logic   due;
      logic   emit;
      logic   slot_ready;
      logic   scan_done;
   } stat_type;

endpackage

[design/crre_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module crre_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[design/crre_datapath.sv]
// Datapath: item and config registers, per-channel row RAM, dispatch logic,
// one-deep result hold stage and output register. Uses crre_pkg and crre_ram.
module crre_datapath #(
   parameter int CHANNELS        = crre_pkg::DEF_CHANNELS,
   parameter int MAX_FRAME_BYTES = crre_pkg::DEF_MAX_FRAME_BYTES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [crre_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [1:0]                       req_tuser,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [crre_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [crre_pkg::CSR_DATA_W-1:0]  csr_data,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [crre_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast,
   output logic [1:0]                       rsp_tuser,
   input  crre_pkg::cmd_type                cmd,
   output crre_pkg::stat_type               stat
);

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SC_W = $clog2(CHANNELS + 1);
   localparam int FL_W = $clog2(MAX_FRAME_BYTES + 1);

   typedef struct packed {
      logic [15:0]     seq;
      logic [FL_W-1:0] flen;
      logic [3:0]      mtype;
      logic            armed;
      logic [31:0]     deadline;
   } row_type;

   localparam int ROW_W = $bits(row_type);

   crre_pkg::op_type op_ff, op_in;
   logic [7:0]  ch_ff, ch_in;
   logic [3:0]  type_ff, type_in;
   logic [3:0]  ver_ff, ver_in;
   logic [15:0] seq_ff, seq_in;
   logic [15:0] cnt_ff, cnt_in;
   logic [31:0] now_ff, now_in;

   logic [3:0]  pv_ff, pv_in;
   logic [15:0] delay_ff, delay_in;
   logic [15:0] retry_ff, retry_in;
   logic [3:0]  reqc_ff, reqc_in;
   logic [3:0]  repc_ff, repc_in;
   logic [31:0] lrt_ff, lrt_in;

   logic [SC_W-1:0]     scan_ff, scan_in;
   logic [CHANNELS-1:0] valid_ff, valid_in;
   logic                rd_valid_ff, rd_valid_in;

   logic              held_valid_ff, held_valid_in;
   crre_pkg::rsp_type held_ff, held_in;
   logic              out_valid_ff, out_valid_in;
   crre_pkg::rsp_type out_ff, out_in;
   logic              out_last_ff, out_last_in;

   logic             ram_we, ram_re;
   logic [CH_W-1:0]  ram_waddr, ram_raddr;
   logic [ROW_W-1:0] ram_wdata, ram_rdata;

   row_type     row_rd, send_row, disp_src, disp_row, recv_wr_row;
   logic [31:0] since_rx, since_dl;
   logic        defer, emit, match, push, out_free, slot_ready;
   logic [7:0]  tx_ch;
   logic [16:0] frame_sum;
   crre_pkg::rsp_type new_res;

   // item latch
   assign op_in   = cmd.load ? crre_pkg::op_type'(req_tuser) : op_ff;
   assign ch_in   = cmd.load ? req_tdata[7:0]   : ch_ff;
   assign type_in = cmd.load ? req_tdata[11:8]  : type_ff;
   assign ver_in  = cmd.load ? req_tdata[15:12] : ver_ff;
   assign seq_in  = cmd.load ? req_tdata[31:16] : seq_ff;
   assign cnt_in  = cmd.load ? req_tdata[47:32] : cnt_ff;
   assign now_in  = cmd.load ? req_tdata[79:48] : now_ff;

   assign csr_ready = 1'b1;

   always_comb begin
      pv_in    = pv_ff;
      delay_in = delay_ff;
      retry_in = retry_ff;
      reqc_in  = reqc_ff;
      repc_in  = repc_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            crre_pkg::CSR_PROTOCOL_VERSION: pv_in    = csr_data[3:0];
            crre_pkg::CSR_SEND_DELAY:       delay_in = csr_data;
            crre_pkg::CSR_RETRY_INTERVAL:   retry_in = csr_data;
            crre_pkg::CSR_REQUEST_TYPE:     reqc_in  = csr_data[3:0];
            crre_pkg::CSR_REPLY_TYPE:       repc_in  = csr_data[3:0];
            default: ;
         endcase
      end
   end

   assign lrt_in = cmd.set_lrt ? now_ff : lrt_ff;

   always_comb begin
      scan_in = scan_ff;
      if (cmd.scan_clear) begin
         scan_in = '0;
      end else if (cmd.scan_next) begin
         scan_in = scan_ff + SC_W'(1);
      end
   end

   // item checks
   assign frame_sum = {1'b0, cnt_ff} + 17'(crre_pkg::HEADER_BYTES);

   // row read; rows never written read as zero
   assign ram_re    = cmd.rd_item | cmd.rd_scan;
   assign ram_raddr = cmd.rd_scan ? scan_ff[CH_W-1:0] : ch_ff[CH_W-1:0];
   assign row_rd    = rd_valid_ff ? row_type'(ram_rdata) : '0;
   assign rd_valid_in = ram_re ? valid_ff[ram_raddr] : rd_valid_ff;

   always_comb begin
      send_row      = row_rd;
      send_row.flen = FL_W'(cnt_ff + 16'(crre_pkg::HEADER_BYTES));
      if (op_ff == crre_pkg::OP_SEND) begin
         send_row.seq   = row_rd.seq + 16'd1;
         send_row.mtype = type_ff;
      end else begin
         send_row.seq   = seq_ff;
         send_row.mtype = repc_ff;
      end
   end

   assign disp_src = (op_ff == crre_pkg::OP_TICK) ? row_rd : send_row;
   assign since_rx = now_ff - lrt_ff;
   assign since_dl = now_ff - row_rd.deadline;
   assign defer    = (lrt_ff != 32'd0) && (since_rx < {16'd0, delay_ff});

   always_comb begin
      disp_row       = disp_src;
      disp_row.armed = 1'b0;
      emit           = 1'b0;
      if (disp_src.flen != '0) begin
         if (defer) begin
            disp_row.armed    = 1'b1;
            disp_row.deadline = lrt_ff + {16'd0, delay_ff};
         end else begin
            emit = 1'b1;
            if (disp_src.mtype == reqc_ff) begin
               disp_row.armed    = 1'b1;
               disp_row.deadline = now_ff + {16'd0, retry_ff};
            end else begin
               disp_row.flen = '0;
            end
         end
      end
   end

   // matching reply idles the channel; its timer is left armed
   assign match = (type_ff == repc_ff) && (row_rd.seq == seq_ff);
   always_comb begin
      recv_wr_row      = row_rd;
      recv_wr_row.flen = '0;
   end

   assign ram_we    = cmd.send_disp | cmd.tick_disp | (cmd.recv_row & match);
   assign ram_waddr = (op_ff == crre_pkg::OP_TICK) ? scan_ff[CH_W-1:0] : ch_ff[CH_W-1:0];
   assign ram_wdata = cmd.recv_row ? ROW_W'(recv_wr_row) : ROW_W'(disp_row);

   always_comb begin
      valid_in = valid_ff;
      if (ram_we) begin
         valid_in[ram_waddr] = 1'b1;
      end
   end

   crre_ram #(
      .WIDTH (ROW_W),
      .DEPTH (CHANNELS)
   ) u_row_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // results: held one deep so the final one can be flagged last
   assign tx_ch = (op_ff == crre_pkg::OP_TICK) ? 8'(scan_ff) : ch_ff;
   assign push  = ((cmd.send_disp | cmd.tick_disp) & emit) | cmd.recv_row | cmd.push_status;

   always_comb begin
      new_res.kind    = crre_pkg::KIND_TX;
      new_res.status  = crre_pkg::ST_OK;
      new_res.channel = tx_ch;
      new_res.mtype   = disp_src.mtype;
      new_res.seq     = disp_src.seq;
      new_res.length  = 16'(disp_src.flen);
      if (cmd.push_status) begin
         new_res.kind    = crre_pkg::KIND_STATUS;
         new_res.status  = cmd.st;
         new_res.channel = ch_ff;
         new_res.mtype   = 4'd0;
         new_res.seq     = 16'd0;
         new_res.length  = 16'd0;
      end else if (cmd.recv_row) begin
         new_res.kind    = crre_pkg::KIND_DELIVER;
         new_res.channel = ch_ff;
         new_res.mtype   = type_ff;
         new_res.seq     = seq_ff;
         new_res.length  = cnt_ff - 16'(crre_pkg::HEADER_BYTES);
      end
   end

   assign out_free   = !out_valid_ff || rsp_tready;
   assign slot_ready = !held_valid_ff || out_free;

   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      held_valid_in = held_valid_ff;
      held_in       = held_ff;
      if ((push || cmd.finish) && held_valid_ff) begin
         out_valid_in = 1'b1;
         out_in       = held_ff;
         out_last_in  = cmd.finish;
      end
      if (push) begin
         held_valid_in = 1'b1;
         held_in       = new_res;
      end else if (cmd.finish) begin
         held_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff         <= crre_pkg::RST_PROTOCOL_VERSION;
         delay_ff      <= crre_pkg::RST_SEND_DELAY;
         retry_ff      <= crre_pkg::RST_RETRY_INTERVAL;
         reqc_ff       <= crre_pkg::RST_REQUEST_TYPE;
         repc_ff       <= crre_pkg::RST_REPLY_TYPE;
         lrt_ff        <= '0;
         scan_ff       <= '0;
         valid_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         held_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pv_ff         <= pv_in;
         delay_ff      <= delay_in;
         retry_ff      <= retry_in;
         reqc_ff       <= reqc_in;
         repc_ff       <= repc_in;
         lrt_ff        <= lrt_in;
         scan_ff       <= scan_in;
         valid_ff      <= valid_in;
         rd_valid_ff   <= rd_valid_in;
         held_valid_ff <= held_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      ch_ff       <= ch_in;
      type_ff     <= type_in;
      ver_ff      <= ver_in;
      seq_ff      <= seq_in;
      cnt_ff      <= cnt_in;
      now_ff      <= now_in;
      held_ff     <= held_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_ff.length, out_ff.seq, out_ff.mtype, out_ff.channel,
                        out_ff.status};
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_last_ff;

   assign stat.op          = op_ff;
   assign stat.too_long    = frame_sum > 17'(MAX_FRAME_BYTES);
   assign stat.bad_channel = ch_ff >= 8'(CHANNELS);
   assign stat.too_short   = cnt_ff < 16'(crre_pkg::HEADER_BYTES);
   assign stat.bad_version = ver_ff != pv_ff;
   assign stat.busy        = row_rd.flen != '0;
   assign stat.due         = row_rd.armed && !since_dl[31];
   assign stat.emit        = emit;
   assign stat.slot_ready  = slot_ready;
   assign stat.scan_done   = scan_ff == SC_W'(CHANNELS);

`ifndef SYNTHESIS
   a_hold_flush_room: assert property (@(posedge clock) disable iff (reset)
      (push && held_valid_ff) |-> out_free)
      else $error("held result overwritten while output register is full");

   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == crre_pkg::KIND_STATUS) |-> rsp_tlast)
      else $error("status word not flagged last");

   a_ram_single_access: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("row read and write in the same cycle");
`endif

endmodule

[design/crre_ctrl.sv]
// Controller FSM: sequences checks, row reads, dispatch, result pushes and the
// per-tick channel scan. Uses crre_pkg; drives the datapath through cmd_type.
module crre_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  crre_pkg::stat_type stat,
   output crre_pkg::cmd_type  cmd
);

   localparam int EMIT_W = crre_pkg::EMIT_W;

   crre_pkg::fsm_type    state_ff, state_in;
   crre_pkg::status_type st_ff, st_in;
   logic [EMIT_W-1:0]    emit_cnt_ff, emit_cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= crre_pkg::FSM_IDLE;
         st_ff       <= crre_pkg::ST_OK;
         emit_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         st_ff       <= st_in;
         emit_cnt_ff <= emit_cnt_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      st_in       = st_ff;
      emit_cnt_in = emit_cnt_ff;
      cmd         = '0;
      req_tready  = 1'b0;
      case (state_ff)
         crre_pkg::FSM_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = crre_pkg::FSM_DECODE;
            end
         end
         crre_pkg::FSM_DECODE: begin
            case (stat.op)
               crre_pkg::OP_SEND, crre_pkg::OP_REPLY: begin
                  if (stat.too_long) begin
                     st_in    = crre_pkg::ST_TOO_LONG;
                     state_in = crre_pkg::FSM_STATUS;
                  end else if (stat.bad_channel) begin
                     st_in    = crre_pkg::ST_BAD_CHANNEL;
                     state_in = crre_pkg::FSM_STATUS;
                  end else begin
                     cmd.rd_item = 1'b1;
                     state_in    = crre_pkg::FSM_SEND_CHK;
                  end
               end
               crre_pkg::OP_RECV: begin
                  if (stat.too_short) begin
                     st_in    = crre_pkg::ST_TOO_SHORT;
                     state_in = crre_pkg::FSM_STATUS;
                  end else if (stat.bad_version) begin
                     st_in    = crre_pkg::ST_BAD_VERSION;
                     state_in = crre_pkg::FSM_STATUS;
                  end else begin
                     cmd.set_lrt = 1'b1;
                     if (stat.bad_channel) begin
                        st_in    = crre_pkg::ST_BAD_CHANNEL;
                        state_in = crre_pkg::FSM_STATUS;
                     end else begin
                        cmd.rd_item = 1'b1;
                        st_in       = crre_pkg::ST_OK;
                        state_in    = crre_pkg::FSM_RECV_ROW;
                     end
                  end
               end
               crre_pkg::OP_TICK: begin
                  cmd.scan_clear = 1'b1;
                  emit_cnt_in    = '0;
                  state_in       = crre_pkg::FSM_SCAN_RD;
               end
               default: state_in = crre_pkg::FSM_IDLE;
            endcase
         end
         crre_pkg::FSM_SEND_CHK: begin
            if (stat.slot_ready) begin
               if (stat.busy) begin
                  st_in = crre_pkg::ST_BUSY;
               end else begin
                  cmd.send_disp = 1'b1;
                  st_in         = crre_pkg::ST_OK;
               end
               state_in = crre_pkg::FSM_STATUS;
            end
         end
         crre_pkg::FSM_RECV_ROW: begin
            if (stat.slot_ready) begin
               cmd.recv_row = 1'b1;
               state_in     = crre_pkg::FSM_STATUS;
            end
         end
         crre_pkg::FSM_STATUS: begin
            if (stat.slot_ready) begin
               cmd.push_status = 1'b1;
               cmd.st          = st_ff;
               state_in        = crre_pkg::FSM_FINISH;
            end
         end
         crre_pkg::FSM_FINISH: begin
            if (stat.slot_ready) begin
               cmd.finish = 1'b1;
               state_in   = crre_pkg::FSM_IDLE;
            end
         end
         crre_pkg::FSM_SCAN_RD: begin
            if (stat.scan_done || emit_cnt_ff == EMIT_W'(crre_pkg::RESULT_CAP)) begin
               state_in = crre_pkg::FSM_FINISH;
            end else begin
               cmd.rd_scan = 1'b1;
               state_in    = crre_pkg::FSM_SCAN_EV;
            end
         end
         crre_pkg::FSM_SCAN_EV: begin
            if (!stat.due) begin
               cmd.scan_next = 1'b1;
               state_in      = crre_pkg::FSM_SCAN_RD;
            end else if (!stat.emit) begin
               cmd.tick_disp = 1'b1;
               cmd.scan_next = 1'b1;
               state_in      = crre_pkg::FSM_SCAN_RD;
            end else if (stat.slot_ready) begin
               cmd.tick_disp = 1'b1;
               cmd.scan_next = 1'b1;
               emit_cnt_in   = emit_cnt_ff + EMIT_W'(1);
               state_in      = crre_pkg::FSM_SCAN_RD;
            end
         end
         default: state_in = crre_pkg::FSM_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_emit_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == crre_pkg::FSM_SCAN_EV) |-> (emit_cnt_ff < EMIT_W'(crre_pkg::RESULT_CAP)))
      else $error("tick scan evaluating a channel after the frame cap");
`endif

endmodule

[design/channel_request_retransmit_engine.sv]
// Items are taken one at a time, only while the controller is idle. A tick's frame waits
// in the hold stage for the next frame or the end of the scan. A tick reads and then
// evaluates each channel in turn (FSM_SCAN_RD, FSM_SCAN_EV) and stops after 8 frames;
// the controller waits for a free result slot before each push, so rsp stalls can hold it.
// Reset (synchronous, active high) restores config defaults, clears all rows via valid bits.
module channel_request_retransmit_engine #(
   parameter int CHANNELS        = crre_pkg::DEF_CHANNELS,
   parameter int MAX_FRAME_BYTES = crre_pkg::DEF_MAX_FRAME_BYTES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // channel, message type, version, seq_num, byte_count, now
   input  logic [crre_pkg::REQ_DATA_W-1:0] req_tdata,
   // operation
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status, out_channel, out_type, out_seq, frame_length, one pad bit
   output logic [crre_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // kind
   output logic [1:0]                      rsp_tuser,
   output logic                            rsp_tlast,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [crre_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [crre_pkg::CSR_DATA_W-1:0] csr_data
);

   crre_pkg::cmd_type  cmd;
   crre_pkg::stat_type stat;

   crre_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   crre_datapath #(
      .CHANNELS        (CHANNELS),
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule
